@@ rtl/core/afp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants for the accelerometer filter packetizer
// Holds the gain and packet structures, register indexes and the constants
// of the fixed-point divide by one hundred.
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam int GAIN_W     = 7;
    localparam int AXIS_W     = 16;
    localparam int SAMPLE_W   = 12;
    localparam int AXIS_SHIFT = 4;
    localparam int BYTE_W     = 8;
    localparam int PKT_BYTES  = 9;
    localparam int PKT_W      = PKT_BYTES * BYTE_W;
    localparam int IDX_W      = 4;

    // Filter datapath widths.
    localparam int PPROD_W = AXIS_W + GAIN_W + 1;      // pole gain times previous
    localparam int IPROD_W = SAMPLE_W + GAIN_W + 1;    // input gain times sample
    localparam int ACC_W   = PPROD_W + 1;
    localparam int MAG_W   = ACC_W - 2;                // |acc| stays below 2^23
    localparam int RECIP_W = 24;
    localparam int QPROD_W = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 30;
    localparam int QUOT_W  = QPROD_W - RECIP_SHIFT;

    // ceil(2^30 / 100): exact truncating quotient for any 23-bit magnitude.
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [GAIN_W-1:0] POLE_GAIN_RST  = 7'd90;
    localparam logic [GAIN_W-1:0] INPUT_GAIN_RST = 7'd10;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 1'd1;

    typedef struct packed {
        logic [GAIN_W-1:0] pole_gain;
        logic [GAIN_W-1:0] input_gain;
    } afp_gains_t;

    // Packed so that the first byte sent sits in the lowest bits.
    typedef struct packed {
        logic signed [AXIS_W-1:0] filt_z;
        logic signed [AXIS_W-1:0] filt_y;
        logic signed [AXIS_W-1:0] filt_x;
        logic [15:0]              range_value;
        logic [BYTE_W-1:0]        sample_count;
    } afp_pkt_t;

endpackage

@@ rtl/core/afp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_lane: one axis of the first-order low-pass filter
// Four-stage pipeline: gain products, signed sum and magnitude, multiply by
// the reciprocal of one hundred, then sign restore, saturation and commit.
// ----------------------------------------------------------------------------
module afp_lane
    import afp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  afp_gains_t               gains,
    input  logic [AXIS_W-1:0]        sample_word,
    input  logic                     commit,
    output logic signed [AXIS_W-1:0] filtered
);

    logic signed [SAMPLE_W-1:0] sample;
    logic signed [PPROD_W-1:0]  pprod_next, pprod_reg;
    logic signed [IPROD_W-1:0]  iprod_next, iprod_reg;
    logic signed [ACC_W-1:0]    acc;
    logic [MAG_W-1:0]           mag_next, mag_reg;
    logic                       neg_reg, neg2_reg;
    logic [QPROD_W-1:0]         qprod_reg;
    logic [QUOT_W-1:0]          quot;
    logic signed [QUOT_W:0]     quot_s;
    logic signed [AXIS_W-1:0]   filt_next, filt_reg;

    assign sample = $signed(sample_word[AXIS_W-1:AXIS_SHIFT]);

    assign pprod_next = $signed({1'b0, gains.pole_gain}) * filt_reg;
    assign iprod_next = $signed({1'b0, gains.input_gain}) * sample;

    assign acc      = ACC_W'(pprod_reg) + ACC_W'(iprod_reg);
    assign mag_next = acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);

    // Truncation toward zero: divide the magnitude, then put the sign back.
    assign quot   = qprod_reg[QPROD_W-1:RECIP_SHIFT];
    assign quot_s = neg2_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_comb
    begin
        if (quot_s > $signed((QUOT_W+1)'(32767)))
            filt_next = 16'sh7FFF;
        else if (quot_s < -$signed((QUOT_W+1)'(32768)))
            filt_next = 16'sh8000;
        else
            filt_next = AXIS_W'(quot_s);
    end

    always_ff @(posedge clk)
    begin
        pprod_reg <= pprod_next;
        iprod_reg <= iprod_next;
        mag_reg   <= mag_next;
        neg_reg   <= acc[ACC_W-1];
        qprod_reg <= QPROD_W'(mag_reg) * QPROD_W'(RECIP_100);
        neg2_reg  <= neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filt_reg <= '0;
        else if (commit)
            filt_reg <= filt_next;
    end

    assign filtered = filt_reg;

endmodule

@@ rtl/core/afp_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_packer: merges the lane results into a nine-byte packet stream
// Loads a whole packet and shifts it out one byte per word, low byte first.
// ----------------------------------------------------------------------------
module afp_packer
    import afp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    input  afp_pkt_t          pkt,
    output logic              pkt_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,
    output logic              m_axis_tlast
);

    logic               act_reg, act_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PKT_W-1:0]   data_reg, data_next;
    logic               xfer;
    logic               last;

    assign last      = (idx_reg == IDX_W'(PKT_BYTES - 1));
    assign xfer      = act_reg && m_axis_tready;
    assign pkt_ready = !act_reg || (xfer && last);

    always_comb
    begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        data_next = data_reg;
        if (pkt_valid && pkt_ready)
        begin
            act_next  = 1'b1;
            idx_next  = '0;
            data_next = pkt;
        end
        else if (xfer)
        begin
            if (last)
                act_next = 1'b0;
            idx_next  = idx_reg + 1'b1;
            data_next = data_reg >> BYTE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_axis_tvalid = act_reg;
    assign m_axis_tdata  = data_reg[BYTE_W-1:0];
    assign m_axis_tlast  = last;

endmodule

@@ rtl/core/accel_filter_packetizer_core.sv @@
`timescale 1ns / 1ps
// Overlap: the 9-byte serializer limits the input rate; the 4-stage filter lanes
// overlap with it, as a new word may enter them while a packet is still sent.
// Reset: rst_n clears the counter, the filter state and all handshake state,
// and restores pole_gain to 90 and input_gain to 10.
// ----------------------------------------------------------------------------
// accel_filter_packetizer_core: three-axis low-pass filter and packet builder
// Three identical filter lanes process x, y and z in parallel; a packer
// serializes counter, distance and the filtered axes into a nine-byte packet.
// ----------------------------------------------------------------------------
module accel_filter_packetizer_core
    import afp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: x_low, x_high, y_low, y_high, z_low, z_high, range_value[15:0]
    input  logic [63:0]          s_axis_tdata,
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: packet_byte[7:0]
    output logic [BYTE_W-1:0]    m_axis_tdata,
    // tlast: last_byte
    output logic                 m_axis_tlast
);

    afp_gains_t               gains_reg;
    logic [BYTE_W-1:0]        count_reg;
    logic [15:0]              range_reg;
    logic [2:0]               pipe_vld_reg;
    logic                     pend_vld_reg;
    logic                     accept;
    logic                     commit;
    logic                     pkt_ready;
    logic                     pkt_load;
    logic signed [AXIS_W-1:0] filt_x, filt_y, filt_z;
    afp_pkt_t                 pkt;

    // Configuration writes. Only two registers exist, so every index is valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.pole_gain  <= POLE_GAIN_RST;
            gains_reg.input_gain <= INPUT_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POLE_GAIN:  gains_reg.pole_gain  <= cfg_data;
                REG_INPUT_GAIN: gains_reg.input_gain <= cfg_data;
                default:        gains_reg            <= gains_reg;
            endcase
        end
    end

    // The filter is a recurrence, so only one word is in the lanes at a time.
    // A finished result waits in the pending slot while the packer still sends
    // the previous packet; once the packer takes it, the next word may enter the lanes.
    assign s_axis_tready = !(|pipe_vld_reg) && !pend_vld_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = pipe_vld_reg[2];
    assign pkt_load      = pend_vld_reg && pkt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
            pend_vld_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            pipe_vld_reg <= {pipe_vld_reg[1:0], accept};
            if (commit)
                pend_vld_reg <= 1'b1;
            else if (pkt_load)
                pend_vld_reg <= 1'b0;
            // The counter is bumped before the packet is built.
            if (accept)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            range_reg <= s_axis_tdata[63:48];
    end

    // One lane per axis; each takes its little-endian axis word.
    afp_lane u_lane_x
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .sample_word (s_axis_tdata[15:0]),
        .commit      (commit),
        .filtered    (filt_x)
    );

    afp_lane u_lane_y
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .sample_word (s_axis_tdata[31:16]),
        .commit      (commit),
        .filtered    (filt_y)
    );

    afp_lane u_lane_z
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .sample_word (s_axis_tdata[47:32]),
        .commit      (commit),
        .filtered    (filt_z)
    );

    // The lane outputs and count stay put until the next word is accepted,
    // and that cannot happen while the pending slot is full.
    assign pkt.sample_count = count_reg;
    assign pkt.range_value  = range_reg;
    assign pkt.filt_x       = filt_x;
    assign pkt.filt_y       = filt_y;
    assign pkt.filt_z       = filt_z;

    afp_packer u_packer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt_valid     (pend_vld_reg),
        .pkt           (pkt),
        .pkt_ready     (pkt_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // At most one word travels through the lanes.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(pipe_vld_reg))
        else $error("more than one word in the filter lanes");

    // A lane result never overwrites a packet that has not been handed over.
    assert property (@(posedge clk) disable iff (!rst_n) commit |-> !pend_vld_reg)
        else $error("filter result committed while pending slot full");

    // A new packet is loaded only when the packer is idle or finishing.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_load |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
        else $error("packet loaded over one still being sent");

    // Every accepted word advances the sample counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("sample counter did not advance");

endmodule

@@ verif/accel_filter_packetizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_filter_packetizer_core_tb: self-checking bench for the filter packetizer
// Streams accelerometer and distance words into the core under several gain
// settings, predicts each nine-byte packet in a small scoreboard class and
// compares every byte and its last flag as it leaves the core.
// ----------------------------------------------------------------------------
module accel_filter_packetizer_core_tb;

    import afp_pkg::*;

    // One expected output word: a packet byte and its last flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } pkt_byte_t;

    // Tracks the filter state and the bytes that the core still owes us.
    class filter_packet_model;
        logic [GAIN_W-1:0]        pole_gain;
        logic [GAIN_W-1:0]        input_gain;
        logic [BYTE_W-1:0]        sample_count;
        logic signed [AXIS_W-1:0] filt_x;
        logic signed [AXIS_W-1:0] filt_y;
        logic signed [AXIS_W-1:0] filt_z;
        pkt_byte_t                pending_bytes[$];
        int                       mismatch_count;

        function new();
            pole_gain      = POLE_GAIN_RST;
            input_gain     = INPUT_GAIN_RST;
            sample_count   = '0;
            filt_x         = '0;
            filt_y         = '0;
            filt_z         = '0;
            mismatch_count = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
            if (idx == REG_POLE_GAIN)
                pole_gain = val;
            else if (idx == REG_INPUT_GAIN)
                input_gain = val;
        endfunction

        // The raw axis word is taken as signed and drops its four low bits,
        // leaving a 12-bit sample.
        function int axis_sample(logic [AXIS_W-1:0] raw);
            logic signed [AXIS_W-1:0] word;
            word = raw;
            return int'(word) >>> AXIS_SHIFT;
        endfunction

        // One step of the low-pass: weighted sum over one hundred, truncated
        // toward zero, then clipped to the 16-bit signed range.
        function logic signed [AXIS_W-1:0] lowpass_step(logic signed [AXIS_W-1:0] prev,
                                                        int sample);
            int acc;
            int quot;
            acc  = int'(pole_gain) * int'(prev) + int'(input_gain) * sample;
            quot = acc / 100;
            if (quot > 32767)
                quot = 32767;
            if (quot < -32768)
                quot = -32768;
            return quot[AXIS_W-1:0];
        endfunction

        function void note_sample(logic [63:0] word);
            afp_pkt_t  pkt;
            pkt_byte_t item;
            sample_count = sample_count + 8'd1;
            filt_x = lowpass_step(filt_x, axis_sample(word[15:0]));
            filt_y = lowpass_step(filt_y, axis_sample(word[31:16]));
            filt_z = lowpass_step(filt_z, axis_sample(word[47:32]));
            pkt.sample_count = sample_count;
            pkt.range_value  = word[63:48];
            pkt.filt_x       = filt_x;
            pkt.filt_y       = filt_y;
            pkt.filt_z       = filt_z;
            for (int k = 0; k < PKT_BYTES; k++)
            begin
                item.data = pkt[k*BYTE_W +: BYTE_W];
                item.last = (k == PKT_BYTES - 1);
                pending_bytes.push_back(item);
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic last);
            pkt_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected output word: packet_byte %0h last_byte %0b", data, last);
                mismatch_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("packet_byte: expected %0h, actual %0h", want.data, data);
                mismatch_count++;
            end
            if (last !== want.last)
            begin
                $error("last_byte: expected %0b, actual %0b", want.last, last);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: x_low, x_high, y_low, y_high, z_low, z_high, range_value[15:0]
    logic [63:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: packet_byte[7:0]
    logic [BYTE_W-1:0]    m_axis_tdata;
    // tlast: last_byte
    logic                 m_axis_tlast;

    // When set, neither side inserts idle cycles any more.
    bit                   quiet = 1'b0;
    filter_packet_model   model;

    accel_filter_packetizer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case a word never arrives.
    initial
    begin
        #2000000;
        $display("accel_filter_packetizer_core_tb: FAIL");
        $finish;
    end

    // Every output word accepted at an edge is checked against the oldest
    // expected byte.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_byte(m_axis_tdata, m_axis_tlast);
    end

    // Receiver: ready most of the time, with stall bursts of random length.
    initial
    begin
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // The x word sits in the lowest bits, low byte first, range on top.
    function automatic logic [63:0] pack_sample(logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z, logic [15:0] range_value);
        return {range_value, z, y, x};
    endfunction

    function automatic logic [15:0] pick_axis();
        logic [15:0] corners[7];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0010, 16'hFFF0, 16'h7FF0};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 6)];
        return 16'($urandom);
    endfunction

    // Offers one word and holds it until the core takes it. A random gap may
    // come first; valid stays high between back-to-back words.
    task automatic send_sample(input logic [63:0] word);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        model.note_sample(word);
    endtask

    // Stops the input stream and waits until the last packet is out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (model.outstanding() != 0)
            @(posedge clk);
    endtask

    // Writes the pole gain, then the input gain; only called with the core idle.
    task automatic load_gains(input logic [GAIN_W-1:0] pole, input logic [GAIN_W-1:0] inp);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_POLE_GAIN;
        cfg_data  <= pole;
        @(posedge clk);
        model.set_gain(REG_POLE_GAIN, pole);
        cfg_index <= REG_INPUT_GAIN;
        cfg_data  <= inp;
        @(posedge clk);
        model.set_gain(REG_INPUT_GAIN, inp);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [GAIN_W-1:0] pole_list[7];
        logic [GAIN_W-1:0] inp_list[7];
        logic [GAIN_W-1:0] pole;
        logic [GAIN_W-1:0] inp;

        pole_list = '{7'd90, 7'd100, 7'd0, 7'd127, 7'd0, 7'd127, 7'd50};
        inp_list  = '{7'd10, 7'd0, 7'd100, 7'd127, 7'd0, 7'd0, 7'd50};
        model = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the gains left at their reset values. The
        // first packet must carry a count of one.
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(pack_sample(16'h7FF0, 16'h8000, 16'h0008, 16'h00FF));
        send_sample(pack_sample(16'h8000, 16'h7FFF, 16'hFFF0, 16'hFF00));
        drain();

        // Gains above one hundred make the loop grow: x and z run into the
        // positive bound, y into the negative one.
        load_gains(7'd127, 7'd127);
        for (int i = 0; i < 12; i++)
            send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h7FF0, 16'($urandom)));
        drain();

        // Only the pole weight: the clipped values must stay clipped.
        load_gains(7'd127, 7'd0);
        send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 16'h5AA5));
        drain();

        // Only the input weight: the history is dropped entirely.
        load_gains(7'd0, 7'd127);
        send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h8000, 16'hA55A));
        drain();

        // Random part: a dozen phases with fixed and random gain pairs. Every
        // phase boundary lets the output side run dry first. The sample count
        // wraps past 255 somewhere in here.
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 7)
            begin
                pole = pole_list[phase];
                inp  = inp_list[phase];
            end
            else
            begin
                pole = 7'($urandom_range(0, 127));
                inp  = 7'($urandom_range(0, 127));
            end
            load_gains(pole, inp);
            if (phase == 11)
                quiet = 1'b1;
            for (int i = 0; i < 32; i++)
                send_sample(pack_sample(pick_axis(), pick_axis(), pick_axis(),
                                        16'($urandom)));
            drain();
        end

        repeat (20) @(posedge clk);
        if (model.mismatch_count == 0)
            $display("accel_filter_packetizer_core_tb: PASS");
        else
            $display("accel_filter_packetizer_core_tb: FAIL");
        $finish;
    end

endmodule
